@@ rtl/ohp_pkg.sv @@
// Object header parser package: field widths, phase and status codes,
// parser state and result structs, and a saturating increment function.
// No dependencies.
package ohp_pkg;

    localparam int SIZE_BITS   = 64;
    localparam int OFFSET_BITS = 32;
    localparam int TBS_W       = 9;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 4;
    localparam int CSIZE_W     = 64;
    localparam int POFF_W      = 32;
    localparam int CMP_W       = (OFFSET_BITS > TBS_W) ? OFFSET_BITS : TBS_W;
    localparam int MUL_W       = SIZE_BITS + 4;

    localparam logic [TBS_W-1:0]  TBS_RESET  = TBS_W'(32);
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_TYPE     = 2'd0,
        PH_SIZE     = 2'd1,
        PH_FINISHED = 2'd2
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CONSUMED  = 4'd0,
        ST_TYPE      = 4'd1,
        ST_DONE      = 4'd2,
        ST_NO_SPACE  = 4'd3,
        ST_TYPE_LONG = 4'd4,
        ST_TRUNC     = 4'd5,
        ST_BAD_CHAR  = 4'd6,
        ST_OVERFLOW  = 4'd7,
        ST_NO_NUL    = 4'd8,
        ST_IGNORED   = 4'd9
    } status_t;

    typedef struct packed {
        phase_t                 phase;
        logic [OFFSET_BITS-1:0] position;
        logic [SIZE_BITS-1:0]   size_acc;
        logic                   digit_seen;
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   type_byte;
        logic [CSIZE_W-1:0]  body_size;
        logic [POFF_W-1:0]   body_offset;
    } result_t;

    localparam state_t STATE_CLEAR = '{
        phase:      PH_TYPE,
        position:   '0,
        size_acc:   '0,
        digit_seen: 1'b0
    };

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS-1:0] r;
        r = (v == '1) ? v : v + OFFSET_BITS'(1);
        return r;
    endfunction

endpackage

@@ rtl/ohp_step.sv @@
// Per-byte parser step: next parser state and result for one request.
// Depends on ohp_pkg.
module ohp_step (
    input  ohp_pkg::state_t              cur,
    input  logic [ohp_pkg::BYTE_W-1:0]   header_byte,
    input  logic                         start_req,
    input  logic                         last_byte,
    input  logic [ohp_pkg::TBS_W-1:0]    type_buffer_size,
    output ohp_pkg::state_t              nxt,
    output ohp_pkg::result_t             res
);

    ohp_pkg::state_t                       base;
    logic                                  is_space;
    logic                                  is_nul;
    logic                                  is_digit;
    logic [3:0]                            digit;
    logic [ohp_pkg::MUL_W-1:0]             acc_ext;
    logic [ohp_pkg::MUL_W-1:0]             acc_next;
    logic                                  ovf;
    logic                                  type_long;
    logic [ohp_pkg::OFFSET_BITS-1:0]       pos_inc;

    always_comb
    begin
        base      = start_req ? ohp_pkg::STATE_CLEAR : cur;
        is_space  = (header_byte == ohp_pkg::CHAR_SPACE);
        is_nul    = (header_byte == ohp_pkg::CHAR_NUL);
        is_digit  = (header_byte >= ohp_pkg::CHAR_ZERO) && (header_byte <= ohp_pkg::CHAR_NINE);
        digit     = 4'(header_byte - ohp_pkg::CHAR_ZERO);
        acc_ext   = ohp_pkg::MUL_W'(base.size_acc);
        acc_next  = (acc_ext << 3) + (acc_ext << 1) + ohp_pkg::MUL_W'(digit);
        ovf       = |acc_next[ohp_pkg::MUL_W-1:ohp_pkg::SIZE_BITS];
        type_long = ohp_pkg::CMP_W'(base.position) >= ohp_pkg::CMP_W'(type_buffer_size);
        pos_inc   = ohp_pkg::sat_inc(base.position);
    end

    // next state
    always_comb
    begin
        nxt = base;
        unique case (base.phase)
            ohp_pkg::PH_TYPE:
            begin
                if (!is_space)
                begin
                    if (last_byte)
                        nxt.phase = ohp_pkg::PH_FINISHED;
                    else
                        nxt.position = pos_inc;
                end
                else if (type_long || last_byte)
                    nxt.phase = ohp_pkg::PH_FINISHED;
                else
                begin
                    nxt.phase    = ohp_pkg::PH_SIZE;
                    nxt.position = pos_inc;
                end
            end
            ohp_pkg::PH_SIZE:
            begin
                if (is_nul || !is_digit)
                    nxt.phase = ohp_pkg::PH_FINISHED;
                else
                begin
                    nxt.digit_seen = 1'b1;
                    if (ovf)
                        nxt.phase = ohp_pkg::PH_FINISHED;
                    else
                    begin
                        nxt.size_acc = acc_next[ohp_pkg::SIZE_BITS-1:0];
                        nxt.position = pos_inc;
                        if (last_byte)
                            nxt.phase = ohp_pkg::PH_FINISHED;
                    end
                end
            end
            default:
                nxt.phase = ohp_pkg::PH_FINISHED;
        endcase
    end

    // result
    always_comb
    begin
        res = '{
            status:      ohp_pkg::ST_IGNORED,
            type_byte:   '0,
            body_size:   '0,
            body_offset: '0
        };
        unique case (base.phase)
            ohp_pkg::PH_TYPE:
            begin
                priority if (!is_space && last_byte)
                    res.status = ohp_pkg::ST_NO_SPACE;
                else if (!is_space)
                begin
                    res.status    = ohp_pkg::ST_TYPE;
                    res.type_byte = header_byte;
                end
                else if (type_long)
                    res.status = ohp_pkg::ST_TYPE_LONG;
                else if (last_byte)
                    res.status = ohp_pkg::ST_TRUNC;
                else
                    res.status = ohp_pkg::ST_CONSUMED;
            end
            ohp_pkg::PH_SIZE:
            begin
                priority if (is_nul && !base.digit_seen)
                    res.status = ohp_pkg::ST_NO_NUL;
                else if (is_nul)
                begin
                    res.status      = ohp_pkg::ST_DONE;
                    res.body_size   = ohp_pkg::CSIZE_W'(base.size_acc);
                    res.body_offset = ohp_pkg::POFF_W'(pos_inc);
                end
                else if (!is_digit)
                    res.status = ohp_pkg::ST_BAD_CHAR;
                else if (ovf)
                    res.status = ohp_pkg::ST_OVERFLOW;
                else if (last_byte)
                    res.status = ohp_pkg::ST_NO_NUL;
                else
                    res.status = ohp_pkg::ST_CONSUMED;
            end
            default:
                res.status = ohp_pkg::ST_IGNORED;
        endcase
    end

endmodule

@@ rtl/object_header_parser_core.sv @@
// Object header parser top level: input register, parser state, result register
// and the type buffer size register. Depends on ohp_pkg and ohp_step.
//
//   channel   signals                                             direction
//   in        in_valid/in_ready, header_byte, start_req, last_byte  sink
//   out       out_valid/out_ready, status, type_byte,
//             body_size, body_offset                              source
//   cfg       cfg_valid/cfg_ready, cfg_data                       sink
//
// One request in and one result out per cycle unless out_ready stalls the result;
// each request passes through the input register, then the parser step into the
// result register.
// The parser state (phase, position, size accumulator) feeds back through ohp_step.
// Reset clears the parser to the type phase and the type buffer size to 32.
// A stalled result holds the input register; in_ready stays high while it is empty.
module object_header_parser_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ohp_pkg::BYTE_W-1:0]      header_byte,
    input  logic                            start_req,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ohp_pkg::STATUS_W-1:0]    status,
    output logic [ohp_pkg::BYTE_W-1:0]      type_byte,
    output logic [ohp_pkg::CSIZE_W-1:0]     body_size,
    output logic [ohp_pkg::POFF_W-1:0]      body_offset,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ohp_pkg::TBS_W-1:0]       cfg_data
);

    logic                          s1_valid_reg;
    logic [ohp_pkg::BYTE_W-1:0]    s1_byte_reg;
    logic                          s1_start_reg;
    logic                          s1_last_reg;
    logic                          out_valid_reg;
    ohp_pkg::result_t              res_reg;
    ohp_pkg::result_t              res_next;
    ohp_pkg::state_t               state_reg;
    ohp_pkg::state_t               state_next;
    logic [ohp_pkg::TBS_W-1:0]     tbs_reg;
    logic                          s1_fire;

    assign s1_fire   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign cfg_ready = 1'b1;

    ohp_step u_step (
        .cur              (state_reg),
        .header_byte      (s1_byte_reg),
        .start_req        (s1_start_reg),
        .last_byte        (s1_last_reg),
        .type_buffer_size (tbs_reg),
        .nxt              (state_next),
        .res              (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ohp_pkg::STATE_CLEAR;
            tbs_reg       <= ohp_pkg::TBS_RESET;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                tbs_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg  <= header_byte;
            s1_start_reg <= start_req;
            s1_last_reg  <= last_byte;
        end
        if (s1_fire)
            res_reg <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign type_byte   = res_reg.type_byte;
    assign body_size   = res_reg.body_size;
    assign body_offset = res_reg.body_offset;

    a_done_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.status == ohp_pkg::ST_DONE)
            |-> state_reg.phase == ohp_pkg::PH_FINISHED)
        else $error("done result without finished phase");

    a_type_in_type_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.status == ohp_pkg::ST_TYPE)
            |-> (state_reg.phase == ohp_pkg::PH_TYPE) && (state_reg.position != '0))
        else $error("type byte result outside type phase");

    a_ignored_finished: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.status == ohp_pkg::ST_IGNORED)
            |-> state_reg.phase == ohp_pkg::PH_FINISHED)
        else $error("ignored result while parser active");

    a_type_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.status != ohp_pkg::ST_TYPE) |-> res_reg.type_byte == '0)
        else $error("type byte set on non-type result");

    a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.status != ohp_pkg::ST_DONE)
            |-> (res_reg.body_size == '0) && (res_reg.body_offset == '0))
        else $error("size or offset set on non-done result");

endmodule

@@ tb/object_header_parser_core_tb.sv @@
// Testbench for object_header_parser_core: drives header bytes and type buffer
// size writes, predicts every result and checks it field by field.
// Depends on ohp_pkg and the object_header_parser_core RTL.
module object_header_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 7;
    localparam int STEADY_PHASE = 5;

    typedef struct packed {
        logic [ohp_pkg::BYTE_W-1:0] data;
        logic                       sop;
        logic                       eop;
    } hdr_req_t;

    class parse_scoreboard;
        logic [ohp_pkg::TBS_W-1:0]       type_limit;
        ohp_pkg::phase_t                 ph;
        logic [ohp_pkg::OFFSET_BITS-1:0] pos;
        logic [ohp_pkg::SIZE_BITS-1:0]   acc;
        logic                            seen;
        ohp_pkg::result_t                parse_results_q[$];
        int                              errors;

        function new();
            type_limit = ohp_pkg::TBS_RESET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            ph   = ohp_pkg::PH_TYPE;
            pos  = '0;
            acc  = '0;
            seen = 1'b0;
        endfunction

        function void set_type_limit(input logic [ohp_pkg::TBS_W-1:0] v);
            type_limit = v;
        endfunction

        function int pending();
            return parse_results_q.size();
        endfunction

        function logic [ohp_pkg::OFFSET_BITS-1:0] bump(
            input logic [ohp_pkg::OFFSET_BITS-1:0] v);
            return (v == {ohp_pkg::OFFSET_BITS{1'b1}}) ? v : v + 1'b1;
        endfunction

        function void note_request(input hdr_req_t r);
            ohp_pkg::result_t              res;
            logic [ohp_pkg::SIZE_BITS-1:0] d;
            res.status      = ohp_pkg::ST_IGNORED;
            res.type_byte   = '0;
            res.body_size   = '0;
            res.body_offset = '0;
            if (r.sop)
                restart();
            case (ph)
                ohp_pkg::PH_TYPE:
                begin
                    if (r.data != ohp_pkg::CHAR_SPACE)
                    begin
                        if (r.eop)
                        begin
                            res.status = ohp_pkg::ST_NO_SPACE;
                            ph = ohp_pkg::PH_FINISHED;
                        end
                        else
                        begin
                            res.status    = ohp_pkg::ST_TYPE;
                            res.type_byte = r.data;
                            pos = bump(pos);
                        end
                    end
                    else if (pos >= type_limit)
                    begin
                        res.status = ohp_pkg::ST_TYPE_LONG;
                        ph = ohp_pkg::PH_FINISHED;
                    end
                    else if (r.eop)
                    begin
                        res.status = ohp_pkg::ST_TRUNC;
                        ph = ohp_pkg::PH_FINISHED;
                    end
                    else
                    begin
                        res.status = ohp_pkg::ST_CONSUMED;
                        ph = ohp_pkg::PH_SIZE;
                        pos = bump(pos);
                    end
                end
                ohp_pkg::PH_SIZE:
                begin
                    if (r.data == ohp_pkg::CHAR_NUL)
                    begin
                        if (!seen)
                        begin
                            res.status = ohp_pkg::ST_NO_NUL;
                        end
                        else
                        begin
                            res.status      = ohp_pkg::ST_DONE;
                            res.body_size   = acc;
                            res.body_offset = ohp_pkg::POFF_W'(bump(pos));
                        end
                        ph = ohp_pkg::PH_FINISHED;
                    end
                    else if (r.data < ohp_pkg::CHAR_ZERO || r.data > ohp_pkg::CHAR_NINE)
                    begin
                        res.status = ohp_pkg::ST_BAD_CHAR;
                        ph = ohp_pkg::PH_FINISHED;
                    end
                    else
                    begin
                        d = ohp_pkg::SIZE_BITS'(r.data) - ohp_pkg::SIZE_BITS'(ohp_pkg::CHAR_ZERO);
                        seen = 1'b1;
                        if (acc > ({ohp_pkg::SIZE_BITS{1'b1}} - d) / ohp_pkg::SIZE_BITS'(10))
                        begin
                            res.status = ohp_pkg::ST_OVERFLOW;
                            ph = ohp_pkg::PH_FINISHED;
                        end
                        else
                        begin
                            acc = acc * ohp_pkg::SIZE_BITS'(10) + d;
                            pos = bump(pos);
                            if (r.eop)
                            begin
                                res.status = ohp_pkg::ST_NO_NUL;
                                ph = ohp_pkg::PH_FINISHED;
                            end
                            else
                            begin
                                res.status = ohp_pkg::ST_CONSUMED;
                            end
                        end
                    end
                end
                default:
                begin
                    ph = ohp_pkg::PH_FINISHED;
                end
            endcase
            parse_results_q.push_back(res);
        endfunction

        function void check_result(input logic [ohp_pkg::STATUS_W-1:0] st,
                                   input logic [ohp_pkg::BYTE_W-1:0]   tb,
                                   input logic [ohp_pkg::CSIZE_W-1:0]  cs,
                                   input logic [ohp_pkg::POFF_W-1:0]   po);
            ohp_pkg::result_t e;
            if (parse_results_q.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d", $time, st);
                errors++;
                return;
            end
            e = parse_results_q.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (tb !== e.type_byte)
            begin
                $display("%0t: type_byte expected %h actual %h", $time, e.type_byte, tb);
                errors++;
            end
            if (cs !== e.body_size)
            begin
                $display("%0t: body_size expected %0d actual %0d",
                         $time, e.body_size, cs);
                errors++;
            end
            if (po !== e.body_offset)
            begin
                $display("%0t: body_offset expected %0d actual %0d",
                         $time, e.body_offset, po);
                errors++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    logic [ohp_pkg::BYTE_W-1:0]   header_byte = '0;
    logic                         start_req   = 1'b0;
    logic                         last_byte   = 1'b0;
    logic                         out_valid;
    logic                         out_ready   = 1'b1;
    logic [ohp_pkg::STATUS_W-1:0] status;
    logic [ohp_pkg::BYTE_W-1:0]   type_byte;
    logic [ohp_pkg::CSIZE_W-1:0]  body_size;
    logic [ohp_pkg::POFF_W-1:0]   body_offset;
    logic                         cfg_valid   = 1'b0;
    logic                         cfg_ready;
    logic [ohp_pkg::TBS_W-1:0]    cfg_data    = '0;

    bit                           steady = 1'b0;
    int                           cycles;
    hdr_req_t                     req_q[$];
    parse_scoreboard              sb;

    object_header_parser_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .header_byte (header_byte),
        .start_req   (start_req),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .type_byte   (type_byte),
        .body_size   (body_size),
        .body_offset (body_offset),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 25);
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, type_byte, body_size, body_offset);
    end

    function automatic int idle_gap();
        if (steady)
            return 0;
        if ($urandom_range(0, 99) < 25)
            return $urandom_range(1, 2);
        return 0;
    endfunction

    function automatic void add_req(input logic [ohp_pkg::BYTE_W-1:0] b, input logic s,
                                    input logic l);
        hdr_req_t r;
        r.data = b;
        r.sop  = s;
        r.eop  = l;
        req_q.push_back(r);
    endfunction

    function automatic logic [ohp_pkg::BYTE_W-1:0] rand_byte();
        return ohp_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ohp_pkg::BYTE_W-1:0] type_char();
        logic [ohp_pkg::BYTE_W-1:0] b;
        do
            b = rand_byte();
        while (b == ohp_pkg::CHAR_SPACE);
        return b;
    endfunction

    function automatic logic [ohp_pkg::BYTE_W-1:0] bad_char();
        logic [ohp_pkg::BYTE_W-1:0] b;
        do
            b = rand_byte();
        while (b == ohp_pkg::CHAR_NUL ||
               (b >= ohp_pkg::CHAR_ZERO && b <= ohp_pkg::CHAR_NINE));
        return b;
    endfunction

    function automatic logic [ohp_pkg::BYTE_W-1:0] digit_char();
        return ohp_pkg::CHAR_ZERO + ohp_pkg::BYTE_W'($urandom_range(0, 9));
    endfunction

    function automatic int pick_type_len(input int cap);
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < ((cap <= 40) ? 15 : 3))
        begin
            len = cap - 1 + int'($urandom_range(0, 2));
            if (len < 0)
                len = 0;
            if (len > 300)
                len = 300;
        end
        else if (r < 85)
        begin
            len = $urandom_range(0, 6);
        end
        else
        begin
            len = $urandom_range(0, 12);
        end
        return len;
    endfunction

    task automatic build_header(input int cap);
        int    kind;
        int    base;
        int    n;
        int    i;
        int    cut;
        string s;
        kind = $urandom_range(0, 99);
        base = req_q.size();
        if (kind >= 95)
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                add_req(rand_byte(), $urandom_range(0, 99) < 30,
                        $urandom_range(0, 99) < 30);
        end
        else
        begin
            n = pick_type_len(cap);
            for (i = 0; i < n; i++)
                add_req(type_char(), 1'b0, 1'b0);
            add_req(ohp_pkg::CHAR_SPACE, 1'b0, 1'b0);
            if (kind >= 85 && kind < 90)
            begin
                add_req(ohp_pkg::CHAR_NUL, 1'b0, 1'b0);
            end
            else if (kind >= 80 && kind < 85)
            begin
                case ($urandom_range(0, 3))
                    0: s = "18446744073709551615";
                    1: s = "18446744073709551616";
                    2: s = "99999999999999999999";
                    default:
                    begin
                        s = "1";
                        s.putc(0, 8'("1") + 8'($urandom_range(0, 8)));
                        for (i = 0; i < 20; i++)
                            s = {s, "0"};
                        for (i = 1; i < 21; i++)
                            s.putc(i, digit_char());
                    end
                endcase
                for (i = 0; i < s.len(); i++)
                    add_req(s[i], 1'b0, 1'b0);
                if ($urandom_range(0, 1) == 1)
                    req_q[req_q.size() - 1].eop = 1'b1;
                else
                    add_req(ohp_pkg::CHAR_NUL, 1'b0, 1'b0);
            end
            else if (kind >= 70 && kind < 80)
            begin
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    add_req(digit_char(), 1'b0, 1'b0);
                add_req(bad_char(), 1'b0, 1'b0);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    add_req(digit_char(), 1'b0, 1'b0);
                add_req(ohp_pkg::CHAR_NUL, 1'b0, 1'b0);
                if (kind >= 60 && kind < 70)
                begin
                    cut = $urandom_range(0, req_q.size() - base - 1);
                    req_q[base + cut].eop = 1'b1;
                    while (req_q.size() > base + cut + 1)
                        void'(req_q.pop_back());
                end
                else
                begin
                    n = $urandom_range(0, 2);
                    for (i = 0; i < n; i++)
                        add_req(rand_byte(), 1'b0, $urandom_range(0, 1) == 1);
                end
            end
            req_q[base].sop = !(kind >= 90 && kind < 95);
        end
    endtask

    task automatic send_request(input hdr_req_t r);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        header_byte <= r.data;
        start_req   <= r.sop;
        last_byte   <= r.eop;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic send_all();
        while (req_q.size() > 0)
            send_request(req_q.pop_front());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_type_limit(input logic [ohp_pkg::TBS_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_type_limit(v);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int  plan[NUM_PHASES];
        int  p;
        int  count;
        bit  paused;
        sb = new();
        plan = '{1, 256, 0, 511, 5, 0, 32};
        plan[STEADY_PHASE] = $urandom_range(2, 40);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_req(8'h78, 1'b0, 1'b0);
        add_req(8'h79, 1'b0, 1'b0);
        add_req(ohp_pkg::CHAR_SPACE, 1'b0, 1'b0);
        add_req(8'h34, 1'b0, 1'b0);
        add_req(8'h32, 1'b0, 1'b0);
        add_req(ohp_pkg::CHAR_NUL, 1'b0, 1'b0);
        add_req(8'hFF, 1'b0, 1'b0);
        add_req(8'h00, 1'b1, 1'b1);
        add_req(ohp_pkg::CHAR_SPACE, 1'b1, 1'b1);
        add_req(ohp_pkg::CHAR_SPACE, 1'b1, 1'b0);
        add_req(ohp_pkg::CHAR_NUL, 1'b0, 1'b0);
        add_req(ohp_pkg::CHAR_SPACE, 1'b1, 1'b0);
        add_req(8'h2F, 1'b0, 1'b0);
        add_req(8'h61, 1'b1, 1'b0);
        add_req(ohp_pkg::CHAR_SPACE, 1'b0, 1'b0);
        add_req(8'h37, 1'b0, 1'b1);
        add_req(ohp_pkg::CHAR_SPACE, 1'b1, 1'b0);
        add_req(ohp_pkg::CHAR_NINE, 1'b0, 1'b0);
        add_req(8'h3A, 1'b0, 1'b0);
        add_req(ohp_pkg::CHAR_SPACE, 1'b1, 1'b0);
        add_req(ohp_pkg::CHAR_NINE, 1'b0, 1'b0);
        add_req(ohp_pkg::CHAR_NUL, 1'b0, 1'b1);
        send_all();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_type_limit(ohp_pkg::TBS_W'(plan[p]));
            steady = (p == STEADY_PHASE);
            count  = 0;
            paused = 1'b0;
            while (count < PHASE_ITEMS)
            begin
                build_header(plan[p]);
                count += req_q.size();
                send_all();
                if (!paused && count >= PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
            steady = 1'b0;
        end

        drain();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
